/* rtl/core/tssc_pkg.sv */
// shared widths, sizes and types for the tftp send session control block
// no dependencies; used by every module under rtl/core
package tssc_pkg;

    // ack delay window
    localparam int DELAY_WINDOW = 21;
    localparam int DELAY_BITS   = 24;

    localparam int HEAD_W = (DELAY_WINDOW > 1) ? $clog2(DELAY_WINDOW) : 1;
    localparam int CNT_W  = $clog2(DELAY_WINDOW + 1);
    localparam int SUM_W  = DELAY_BITS + $clog2(DELAY_WINDOW);

    // configuration register widths
    localparam int BSIZE_W = 16;
    localparam int THR_W   = 24;

    // slow test: 2*sum >= (2*thr+1)*count
    localparam int PROD_W = THR_W + 1 + CNT_W;
    localparam int CMP_W  = (PROD_W > SUM_W + 1) ? PROD_W : SUM_W + 1;

    // command from the session control to the delay window
    typedef struct packed {
        logic clear;
        logic push;
    } win_cmd_t;

endpackage

/* rtl/core/tssc_delay_ram.sv */
// single-port-write, single-port-read delay sample memory with a registered read
// depends on tssc_pkg for depth and width
module tssc_delay_ram (
    input  logic                                aclk,
    input  logic                                we,
    input  logic [tssc_pkg::HEAD_W-1:0]         waddr,
    input  logic [tssc_pkg::DELAY_BITS-1:0]     wdata,
    input  logic                                re,
    input  logic [tssc_pkg::HEAD_W-1:0]         raddr,
    output logic [tssc_pkg::DELAY_BITS-1:0]     rdata
);

    logic [tssc_pkg::DELAY_BITS-1:0] mem [tssc_pkg::DELAY_WINDOW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/tssc_delay_window.sv */
// sliding window of ack delays: ring memory, head, count, running sum, slow test
// depends on tssc_pkg and tssc_delay_ram
module tssc_delay_window (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                rd_en,
    input  tssc_pkg::win_cmd_t                  cmd,
    input  logic [tssc_pkg::DELAY_BITS-1:0]     delay,
    input  logic [tssc_pkg::THR_W-1:0]          threshold,
    output logic                                over_threshold
);

    logic [tssc_pkg::HEAD_W-1:0]     head_reg, head_next;
    logic [tssc_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [tssc_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [tssc_pkg::DELAY_BITS-1:0] old_delay;
    logic                            full;
    logic [tssc_pkg::PROD_W-1:0]     prod;

    tssc_delay_ram u_ram (
        .aclk  (aclk),
        .we    (cmd.push),
        .waddr (head_reg),
        .wdata (delay),
        .re    (rd_en),
        .raddr (head_reg),
        .rdata (old_delay)
    );

    // window full: the entry at head is the oldest and drops out
    assign full = (cnt_reg >= tssc_pkg::CNT_W'(tssc_pkg::DELAY_WINDOW));

    always_comb begin
        sum_next = sum_reg - (full ? tssc_pkg::SUM_W'(old_delay) : '0)
                 + tssc_pkg::SUM_W'(delay);
        cnt_next = full ? tssc_pkg::CNT_W'(tssc_pkg::DELAY_WINDOW) : cnt_reg + 1'b1;
        head_next = (head_reg == tssc_pkg::HEAD_W'(tssc_pkg::DELAY_WINDOW - 1))
                  ? '0 : head_reg + 1'b1;
    end

    assign prod = tssc_pkg::PROD_W'({threshold, 1'b1}) * tssc_pkg::PROD_W'(cnt_next);
    assign over_threshold = tssc_pkg::CMP_W'({sum_next, 1'b0}) >= tssc_pkg::CMP_W'(prod);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            cnt_reg  <= '0;
            sum_reg  <= '0;
        end else if (cmd.clear) begin
            head_reg <= '0;
            cnt_reg  <= '0;
            sum_reg  <= '0;
        end else if (cmd.push) begin
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
            sum_reg  <= sum_next;
        end
    end

endmodule

/* rtl/core/tftp_send_session_control_unit.sv */
// top level of the tftp send session control: stream ports, apb registers, session fsm
// depends on tssc_pkg and tssc_delay_window
//
// Sending side of a TFTP read transfer. Each input word is one event (start, received
// datagram header, retransmit timeout), selected by s_tuser; each event yields exactly
// one result word carrying the action to take (m_tuser), the block number, error kind,
// stop-timer and slow-network flags and the session state after the event. When an
// event is accepted, the oldest ack delay is read from the window memory at the ring
// head. The event fires once the output register is free or m_tready is high; then
// the session state, the window sum and the memory entry are updated together and the
// result is loaded into the output register. The next word is taken while that result
// still waits on m_tready, so a new event can be accepted before the last result has
// left. The memory needs no clearing pass: the window count limits reads to entries
// written since the last start. Registers (block_size at 0x0, slow_threshold_us at
// 0x4) are to be written by the user between events; the block does not enforce it.
module tftp_send_session_control_unit (
    input  logic        aclk,
    input  logic        aresetn,

    // event input
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] options_acked, [16:1] opcode, [32:17] word_two, [33] too_short,
    // [57:34] ack_delay_us, [73:58] block_len, [79:74] zero
    input  logic [79:0] s_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_tuser,

    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] block_number, [16] error_kind, [17] stop_timer, [18] slow_network,
    // [21:19] session_state, [23:22] zero
    output logic [23:0] m_tdata,
    // [1:0] action
    output logic [1:0]  m_tuser,

    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // session phases
    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_NEGOTIATING = 3'd1,
        PH_BUSY        = 3'd2,
        PH_FINISHED    = 3'd3,
        PH_ERROR       = 3'd4
    } phase_t;

    // event kinds
    localparam logic [1:0] REQ_START    = 2'd0;
    localparam logic [1:0] REQ_DATAGRAM = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT  = 2'd2;

    // actions
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_SEND   = 2'd1;
    localparam logic [1:0] ACT_RESEND = 2'd2;
    localparam logic [1:0] ACT_ERROR  = 2'd3;

    // error kinds sent back
    localparam logic EK_UNDEFINED = 1'b0;
    localparam logic EK_ILLEGAL   = 1'b1;

    // datagram header codes
    localparam logic [15:0] OP_ACK        = 16'd4;
    localparam logic [15:0] OP_ERROR      = 16'd5;
    localparam logic [15:0] ERR_DISK_FULL = 16'd3;
    localparam logic [15:0] ERR_OPT_ABORT = 16'd8;

    // register indexes (paddr[2])
    localparam logic REG_BLOCK_SIZE = 1'b0;
    localparam logic REG_THRESHOLD  = 1'b1;

    localparam logic [tssc_pkg::BSIZE_W-1:0] BSIZE_RESET = 16'd512;
    localparam logic [tssc_pkg::THR_W-1:0]   THR_RESET   = 24'd100000;

    // block number modulo 5 tracking
    localparam logic [2:0] MOD5_LAST = 3'd4;

    // configuration registers
    logic [tssc_pkg::BSIZE_W-1:0] block_size_reg;
    logic [tssc_pkg::THR_W-1:0]   threshold_reg;
    logic                         cfg_write;

    // session state
    phase_t      phase_reg, phase_next;
    logic [15:0] block_reg, block_next;
    logic [2:0]  mod5_reg, mod5_next;
    logic        reported_reg, reported_next;

    // event held while the window memory read completes
    logic        ev_valid_reg;
    logic [1:0]  ev_req_reg;
    logic        ev_opts_reg;
    logic [15:0] ev_opcode_reg;
    logic [15:0] ev_word_two_reg;
    logic        ev_short_reg;
    logic [23:0] ev_delay_reg;
    logic [15:0] ev_blen_reg;

    // output register
    logic        out_valid_reg;
    logic [1:0]  out_action_reg;
    logic [15:0] out_block_reg;
    logic        out_ekind_reg;
    logic        out_stop_reg;
    logic        out_slow_reg;
    logic [2:0]  out_state_reg;

    // event decision
    logic [1:0]          act;
    logic                ekind;
    logic                stop;
    logic                slow;
    logic                go;
    logic                dup_ack;
    logic                over_threshold;
    tssc_pkg::win_cmd_t  win_cmd;
    logic                accept;
    logic                fire;

    // ---------------------------------------------------------------- register port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg <= BSIZE_RESET;
            threshold_reg  <= THR_RESET;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_BLOCK_SIZE: block_size_reg <= pwdata[tssc_pkg::BSIZE_W-1:0];
                REG_THRESHOLD:  threshold_reg  <= pwdata[tssc_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_BLOCK_SIZE: prdata = 32'(block_size_reg);
            REG_THRESHOLD:  prdata = 32'(threshold_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- handshakes
    // one event in flight; the output register decouples the result side
    assign s_tready = !ev_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign fire     = ev_valid_reg && (!out_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_valid_reg <= 1'b0;
        end else if (accept) begin
            ev_valid_reg <= 1'b1;
        end else if (fire) begin
            ev_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ev_req_reg      <= s_tuser;
            ev_opts_reg     <= s_tdata[0];
            ev_opcode_reg   <= s_tdata[16:1];
            ev_word_two_reg <= s_tdata[32:17];
            ev_short_reg    <= s_tdata[33];
            ev_delay_reg    <= s_tdata[57:34];
            ev_blen_reg     <= s_tdata[73:58];
        end
    end

    // ---------------------------------------------------------------- delay window
    // read of the oldest sample issued at accept, read-modify-write at fire
    tssc_delay_window u_window (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .rd_en          (accept),
        .cmd            (win_cmd),
        .delay          (tssc_pkg::DELAY_BITS'(ev_delay_reg)),
        .threshold      (threshold_reg),
        .over_threshold (over_threshold)
    );

    // ---------------------------------------------------------------- session decision
    assign dup_ack = (block_reg != 16'd0) && (ev_word_two_reg == block_reg - 16'd1);

    always_comb begin
        act           = ACT_NONE;
        ekind         = EK_UNDEFINED;
        stop          = 1'b0;
        slow          = 1'b0;
        go            = 1'b0;
        win_cmd       = '0;
        phase_next    = phase_reg;
        block_next    = block_reg;
        mod5_next     = mod5_reg;
        reported_next = reported_reg;

        case (ev_req_reg)
            REQ_START: begin
                // restart: reset block number, clear slow flag and window
                win_cmd.clear = 1'b1;
                reported_next = 1'b0;
                if (ev_opts_reg) begin
                    phase_next = PH_NEGOTIATING;
                    block_next = 16'd0;
                    mod5_next  = 3'd0;
                end else begin
                    phase_next = PH_BUSY;
                    block_next = 16'd1;
                    mod5_next  = 3'd1;
                    act        = ACT_SEND;
                end
            end
            REQ_TIMEOUT: begin
                if (phase_reg == PH_BUSY) begin
                    act = ACT_RESEND;
                end
            end
            REQ_DATAGRAM: begin
                if (phase_reg != PH_IDLE && phase_reg != PH_ERROR) begin
                    if (phase_reg == PH_FINISHED) begin
                        phase_next = PH_ERROR;
                        act        = ACT_ERROR;
                        ekind      = EK_ILLEGAL;
                    end else if (phase_reg == PH_NEGOTIATING && !ev_short_reg &&
                                 ev_opcode_reg == OP_ERROR &&
                                 (ev_word_two_reg == ERR_OPT_ABORT ||
                                  ev_word_two_reg == ERR_DISK_FULL)) begin
                        // client aborted the negotiation
                        phase_next = PH_FINISHED;
                    end else if (ev_short_reg) begin
                        phase_next = PH_ERROR;
                        act        = ACT_ERROR;
                        ekind      = EK_UNDEFINED;
                    end else if (ev_opcode_reg != OP_ACK) begin
                        phase_next = PH_ERROR;
                        act        = ACT_ERROR;
                        ekind      = EK_ILLEGAL;
                    end else begin
                        stop = 1'b1;
                        if (dup_ack) begin
                            // duplicate ack: timer stop only
                        end else if (ev_word_two_reg != block_reg) begin
                            phase_next = PH_ERROR;
                            act        = ACT_ERROR;
                            ekind      = EK_ILLEGAL;
                        end else if (phase_reg == PH_NEGOTIATING) begin
                            phase_next = PH_BUSY;
                            go         = 1'b1;
                        end else if (ev_blen_reg < block_size_reg) begin
                            // short block was the last one
                            phase_next = PH_FINISHED;
                        end else begin
                            go = 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase

        if (go) begin
            if (!reported_reg && block_reg != 16'd0) begin
                win_cmd.push = 1'b1;
                if (mod5_reg == 3'd0 && over_threshold) begin
                    slow          = 1'b1;
                    reported_next = 1'b1;
                end
            end
            block_next = block_reg + 16'd1;
            // 65536 is not a multiple of 5, so reload the residue on wrap
            if (block_reg == 16'hFFFF) begin
                mod5_next = 3'd0;
            end else if (mod5_reg == MOD5_LAST) begin
                mod5_next = 3'd0;
            end else begin
                mod5_next = mod5_reg + 3'd1;
            end
            act = ACT_SEND;
        end

        // window only moves when the event actually completes
        if (!fire) begin
            win_cmd = '0;
        end
    end

    // ---------------------------------------------------------------- state and output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            block_reg     <= '0;
            mod5_reg      <= '0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                phase_reg      <= phase_next;
                block_reg      <= block_next;
                mod5_reg       <= mod5_next;
                reported_reg   <= reported_next;
                out_valid_reg  <= 1'b1;
                out_action_reg <= act;
                out_block_reg  <= block_next;
                out_ekind_reg  <= ekind;
                out_stop_reg   <= stop;
                out_slow_reg   <= slow;
                out_state_reg  <= phase_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_action_reg;
    assign m_tdata  = {2'b00, out_state_reg, out_slow_reg, out_stop_reg,
                       out_ekind_reg, out_block_reg};

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// self-checking testbench for tftp_send_session_control_unit: stream driver, monitor,
// in-line session predictor and apb register writes; depends on tssc_pkg and the rtl only
module tb;

    // request kinds carried on s_tuser
    localparam logic [1:0] REQ_START   = 2'd0;
    localparam logic [1:0] REQ_DGRAM   = 2'd1;
    localparam logic [1:0] REQ_TIMEOUT = 2'd2;
    localparam logic [1:0] REQ_RSVD    = 2'd3;

    // actions carried on m_tuser
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_SEND   = 2'd1;
    localparam logic [1:0] ACT_RESEND = 2'd2;
    localparam logic [1:0] ACT_ERROR  = 2'd3;

    // session states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_NEGOTIATE = 3'd1;
    localparam logic [2:0] ST_BUSY     = 3'd2;
    localparam logic [2:0] ST_FINISHED = 3'd3;
    localparam logic [2:0] ST_ERROR    = 3'd4;

    // tftp opcodes and error codes
    localparam logic [15:0] OPC_ACK        = 16'd4;
    localparam logic [15:0] OPC_ERROR      = 16'd5;
    localparam logic [15:0] ERRC_DISK_FULL = 16'd3;
    localparam logic [15:0] ERRC_OPT_ABORT = 16'd8;

    localparam logic EK_UNDEFINED = 1'b0;
    localparam logic EK_ILLEGAL   = 1'b1;

    // register addresses
    localparam logic [2:0] REG_BLOCK_SIZE = 3'd0;
    localparam logic [2:0] REG_SLOW_THR   = 3'd4;

    localparam int unsigned BLEN_MAX  = 65464;
    localparam int unsigned DELAY_MAX = (1 << tssc_pkg::DELAY_BITS) - 1;

    typedef struct packed {
        logic [1:0]                      req;
        logic                            opts;
        logic [15:0]                     opcode;
        logic [15:0]                     word_two;
        logic                            too_short;
        logic [tssc_pkg::DELAY_BITS-1:0] delay;
        logic [15:0]                     blen;
    } sess_evt_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] blk;
        logic        ekind;
        logic        stop;
        logic        slow;
        logic [2:0]  state;
    } sess_res_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // [0] options_acked, [16:1] opcode, [32:17] word_two, [33] too_short,
    // [57:34] ack_delay_us, [73:58] block_len, [79:74] zero
    logic [79:0] s_tdata  = '0;
    // [1:0] req_type
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // [15:0] block_number, [16] error_kind, [17] stop_timer, [18] slow_network,
    // [21:19] session_state, [23:22] zero
    logic [23:0] m_tdata;
    // [1:0] action
    logic [1:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    tftp_send_session_control_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // shared testbench state
    // ------------------------------------------------------------------
    sess_evt_t   session_evt_q[$];     // words waiting for the driver
    sess_res_t   pending_results[$];   // predicted results, oldest first
    int unsigned err_cnt     = 0;
    int unsigned taken_cnt   = 0;      // input words accepted so far
    int unsigned result_cnt  = 0;
    int unsigned queued_cnt  = 0;      // words generated in the current phase
    bit          fire_last   = 1'b0;   // input handshake at the last rising edge

    // configuration copy, updated on every register write
    logic [tssc_pkg::BSIZE_W-1:0] cfg_bsize = 16'd512;
    logic [tssc_pkg::THR_W-1:0]   cfg_thr   = 24'd100000;

    // predicted session state
    logic [2:0]                      ps_state = ST_IDLE;
    logic [15:0]                     ps_block = '0;
    logic                            ps_slow_seen = 1'b0;
    logic [tssc_pkg::DELAY_BITS-1:0] ps_ring [tssc_pkg::DELAY_WINDOW];
    logic [tssc_pkg::HEAD_W-1:0]     ps_head = '0;
    logic [tssc_pkg::CNT_W-1:0]      ps_cnt  = '0;
    logic [tssc_pkg::SUM_W-1:0]      ps_sum  = '0;

    // ------------------------------------------------------------------
    // session predictor
    // ------------------------------------------------------------------
    function automatic void restart_session();
        ps_state     = ST_IDLE;
        ps_block     = '0;
        ps_slow_seen = 1'b0;
        ps_head      = '0;
        ps_cnt       = '0;
        ps_sum       = '0;
    endfunction

    // add one ack delay to the sliding window, dropping the oldest when full
    function automatic void record_delay(logic [tssc_pkg::DELAY_BITS-1:0] d);
        if (ps_cnt >= tssc_pkg::CNT_W'(tssc_pkg::DELAY_WINDOW)) begin
            ps_sum = ps_sum - tssc_pkg::SUM_W'(ps_ring[ps_head]);
            ps_cnt = tssc_pkg::CNT_W'(tssc_pkg::DELAY_WINDOW - 1);
        end
        ps_ring[ps_head] = d;
        ps_sum = ps_sum + tssc_pkg::SUM_W'(d);
        ps_cnt = ps_cnt + 1'b1;
        ps_head = (ps_head == tssc_pkg::HEAD_W'(tssc_pkg::DELAY_WINDOW - 1))
                ? '0 : ps_head + 1'b1;
    endfunction

    function automatic sess_res_t predict_session(sess_evt_t ev);
        sess_res_t r;
        logic      go;
        longint    lhs;
        longint    rhs;
        r = '0;
        case (ev.req)
            REQ_START: begin
                restart_session();
                if (ev.opts) begin
                    ps_state = ST_NEGOTIATE;
                end else begin
                    ps_state = ST_BUSY;
                    ps_block = 16'd1;
                    r.action = ACT_SEND;
                end
            end
            REQ_TIMEOUT: begin
                if (ps_state == ST_BUSY)
                    r.action = ACT_RESEND;
            end
            REQ_DGRAM: begin
                // idle and error phases ignore datagrams
                if (ps_state != ST_IDLE && ps_state != ST_ERROR) begin
                    if (ps_state == ST_FINISHED) begin
                        ps_state = ST_ERROR;
                        r.action = ACT_ERROR;
                        r.ekind  = EK_ILLEGAL;
                    end else if (ps_state == ST_NEGOTIATE && !ev.too_short &&
                                 ev.opcode == OPC_ERROR &&
                                 (ev.word_two == ERRC_OPT_ABORT ||
                                  ev.word_two == ERRC_DISK_FULL)) begin
                        // peer aborted the negotiation
                        ps_state = ST_FINISHED;
                    end else if (ev.too_short) begin
                        ps_state = ST_ERROR;
                        r.action = ACT_ERROR;
                        r.ekind  = EK_UNDEFINED;
                    end else if (ev.opcode != OPC_ACK) begin
                        ps_state = ST_ERROR;
                        r.action = ACT_ERROR;
                        r.ekind  = EK_ILLEGAL;
                    end else begin
                        r.stop = 1'b1;
                        if (ps_block != 16'd0 && ev.word_two == ps_block - 16'd1) begin
                            // duplicate ack, only the timer stops
                        end else if (ev.word_two != ps_block) begin
                            ps_state = ST_ERROR;
                            r.action = ACT_ERROR;
                            r.ekind  = EK_ILLEGAL;
                        end else begin
                            go = 1'b1;
                            if (ps_state == ST_NEGOTIATE) begin
                                ps_state = ST_BUSY;
                            end else if (ev.blen < cfg_bsize) begin
                                ps_state = ST_FINISHED;
                                go = 1'b0;
                            end
                            if (go) begin
                                if (!ps_slow_seen && ps_block != 16'd0) begin
                                    record_delay(ev.delay);
                                    lhs = longint'(ps_sum) * 2;
                                    rhs = (longint'(cfg_thr) * 2 + 1) * longint'(ps_cnt);
                                    if (ps_block % 16'd5 == 16'd0 && lhs >= rhs) begin
                                        r.slow = 1'b1;
                                        ps_slow_seen = 1'b1;
                                    end
                                end
                                ps_block = ps_block + 16'd1;
                                r.action = ACT_SEND;
                            end
                        end
                    end
                end
            end
            default: ;   // reserved request kind does nothing
        endcase
        r.blk   = ps_block;
        r.state = ps_state;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (err_cnt < 50)
            $display("mismatch: %s on result %0d, got %0d, expected %0d",
                     what, result_cnt, got, want);
        err_cnt++;
    endtask

    // monitor: results are checked before the same edge's input is predicted,
    // a word accepted at this edge cannot have its result out yet
    always @(posedge aclk) begin
        sess_evt_t ev;
        sess_res_t got;
        sess_res_t want;
        fire_last = 1'b0;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.action = m_tuser;
                got.blk    = m_tdata[15:0];
                got.ekind  = m_tdata[16];
                got.stop   = m_tdata[17];
                got.slow   = m_tdata[18];
                got.state  = m_tdata[21:19];
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending", got, 0);
                end else begin
                    want = pending_results.pop_front();
                    if (got.action != want.action)
                        report_mismatch("action", got.action, want.action);
                    if (got.blk != want.blk)
                        report_mismatch("block_number", got.blk, want.blk);
                    if (got.ekind != want.ekind)
                        report_mismatch("error_kind", got.ekind, want.ekind);
                    if (got.stop != want.stop)
                        report_mismatch("stop_timer", got.stop, want.stop);
                    if (got.slow != want.slow)
                        report_mismatch("slow_network", got.slow, want.slow);
                    if (got.state != want.state)
                        report_mismatch("session_state", got.state, want.state);
                end
                result_cnt++;
            end
            if (s_tvalid && s_tready) begin
                ev.req       = s_tuser;
                ev.opts      = s_tdata[0];
                ev.opcode    = s_tdata[16:1];
                ev.word_two  = s_tdata[32:17];
                ev.too_short = s_tdata[33];
                ev.delay     = s_tdata[57:34];
                ev.blen      = s_tdata[73:58];
                pending_results.insert(pending_results.size(), predict_session(ev));
                taken_cnt++;
                fire_last = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // driver: bursts of random length with random gaps between them
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(negedge aclk) begin
        sess_evt_t ev;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !fire_last) begin
            // word still waiting for s_tready, hold it
        end else if (gap_left != 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (session_evt_q.size() != 0) begin
            ev = session_evt_q.pop_front();
            s_tvalid <= 1'b1;
            s_tuser  <= ev.req;
            s_tdata  <= {6'b0, ev.blen, ev.delay, ev.too_short, ev.word_two,
                         ev.opcode, ev.opts};
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                // about a third of the bursts are followed by no gap at all
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end else begin
                burst_left--;
            end
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // receiver: stall pattern in random segments, plus one long hold-off
    // that fills the block while the driver keeps offering words
    // ------------------------------------------------------------------
    int unsigned seg_left  = 0;
    int unsigned rx_mode   = 0;
    int unsigned rx_tick   = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (!hold_done && taken_cnt >= 400) begin
            hold_done = 1'b1;
            hold_left = 300;
            m_tready <= 1'b0;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(1, 60);
                rx_mode  = $urandom_range(0, 3);
            end else begin
                seg_left--;
            end
            rx_tick++;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                2:       m_tready <= (rx_tick % 4 == 0);
                default: m_tready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_evt(logic [1:0] req, logic opts, logic [15:0] opcode,
                            logic [15:0] word_two, logic too_short,
                            logic [tssc_pkg::DELAY_BITS-1:0] delay, logic [15:0] blen);
        sess_evt_t ev;
        ev.req       = req;
        ev.opts      = opts;
        ev.opcode    = opcode;
        ev.word_two  = word_two;
        ev.too_short = too_short;
        ev.delay     = delay;
        ev.blen      = blen;
        session_evt_q.insert(session_evt_q.size(), ev);
        queued_cnt++;
    endtask

    // word whose unused fields carry random content
    task automatic push_filler(logic [1:0] req, logic opts);
        push_evt(req, opts, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 1'($urandom_range(0, 1)),
                 tssc_pkg::DELAY_BITS'($urandom_range(0, DELAY_MAX)),
                 16'($urandom_range(0, BLEN_MAX)));
    endtask

    task automatic push_ack(logic [15:0] blk, logic [tssc_pkg::DELAY_BITS-1:0] delay,
                            logic [15:0] blen);
        push_evt(REQ_DGRAM, 1'b0, OPC_ACK, blk, 1'b0, delay, blen);
    endtask

    // delays spread over the full range, with many close to the threshold
    function automatic logic [tssc_pkg::DELAY_BITS-1:0] pick_delay();
        longint v;
        case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, DELAY_MAX);
            1:       v = 0;
            2:       v = DELAY_MAX;
            3, 4:    v = $urandom_range(0, 2 * cfg_thr + 2);
            default: v = longint'(cfg_thr) + $urandom_range(0, 2) - 1;
        endcase
        if (v < 0)
            v = 0;
        if (v > DELAY_MAX)
            v = DELAY_MAX;
        return tssc_pkg::DELAY_BITS'(v);
    endfunction

    function automatic logic [15:0] full_len();
        return 16'($urandom_range(cfg_bsize, BLEN_MAX));
    endfunction

    // one broken or meaningless word
    task automatic push_noise();
        case ($urandom_range(0, 5))
            0: push_filler(REQ_RSVD, 1'($urandom_range(0, 1)));
            1: push_filler(REQ_DGRAM, 1'($urandom_range(0, 1)));
            2: push_evt(REQ_DGRAM, 1'b0, 16'($urandom_range(0, 65535)),
                        16'($urandom_range(0, 65535)), 1'b1, pick_delay(), full_len());
            3: push_ack(16'($urandom_range(0, 65535)), pick_delay(), full_len());
            4: push_evt(REQ_DGRAM, 1'b0, OPC_ERROR, 16'($urandom_range(0, 15)), 1'b0,
                        pick_delay(), full_len());
            default: push_filler(REQ_TIMEOUT, 1'b0);
        endcase
    endtask

    // one well-formed session with random content, sometimes broken by noise
    task automatic gen_session();
        logic        opts;
        logic [15:0] blk;
        int unsigned nblk;
        opts = ($urandom_range(0, 9) < 4);
        push_filler(REQ_START, opts);
        blk = opts ? 16'd0 : 16'd1;
        if (opts) begin
            if ($urandom_range(0, 9) == 0) begin
                push_evt(REQ_DGRAM, 1'b0, OPC_ERROR,
                         $urandom_range(0, 1) ? ERRC_OPT_ABORT : ERRC_DISK_FULL, 1'b0,
                         pick_delay(), full_len());
                if ($urandom_range(0, 1))
                    push_filler(REQ_DGRAM, 1'b0);
                return;
            end
            push_ack(16'd0, pick_delay(), 16'($urandom_range(0, BLEN_MAX)));
            blk = 16'd1;
        end
        nblk = $urandom_range(1, 40);
        repeat (nblk) begin
            if ($urandom_range(0, 4) == 0)
                push_filler(REQ_TIMEOUT, 1'b0);
            if ($urandom_range(0, 9) == 0)
                push_ack(blk - 16'd1, pick_delay(), full_len());
            if ($urandom_range(0, 29) == 0) begin
                push_noise();
                return;
            end
            push_ack(blk, pick_delay(), full_len());
            blk++;
        end
        // short block ends the transfer
        push_ack(blk, pick_delay(), 16'($urandom_range(0, cfg_bsize - 1)));
        case ($urandom_range(0, 3))
            0:       push_filler(REQ_DGRAM, 1'b0);
            1:       push_filler(REQ_TIMEOUT, 1'b0);
            default: ;
        endcase
    endtask

    // apb write: setup cycle then access cycle, driven at falling edges
    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == REG_BLOCK_SIZE)
            cfg_bsize = data[tssc_pkg::BSIZE_W-1:0];
        else if (addr == REG_SLOW_THR)
            cfg_thr = data[tssc_pkg::THR_W-1:0];
    endtask

    // wait until every queued word is taken and every result has come back
    task automatic wait_drained();
        while (session_evt_q.size() != 0 || s_tvalid || pending_results.size() != 0) begin
            @(posedge aclk);
            #1;
        end
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin : stim
        int unsigned ph;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part, reset register values
        push_filler(REQ_RSVD, 1'b0);                       // reserved kind in idle
        push_filler(REQ_DGRAM, 1'b0);                      // datagram ignored in idle
        push_filler(REQ_TIMEOUT, 1'b0);                    // timeout ignored in idle
        push_filler(REQ_START, 1'b1);                      // wait for ack 0
        push_filler(REQ_TIMEOUT, 1'b0);                    // no resend while negotiating
        push_evt(REQ_DGRAM, 1'b0, OPC_ERROR, ERRC_OPT_ABORT, 1'b0, 24'd0, 16'd0);
        push_ack(16'd0, 24'd0, 16'd0);                     // any datagram when finished
        push_ack(16'd0, 24'd0, 16'd0);                     // ignored in error phase
        push_filler(REQ_TIMEOUT, 1'b0);
        push_filler(REQ_START, 1'b1);
        // short datagram wins over an otherwise valid disk-full abort
        push_evt(REQ_DGRAM, 1'b0, OPC_ERROR, ERRC_DISK_FULL, 1'b1, 24'd0, 16'd0);
        push_filler(REQ_START, 1'b1);
        push_ack(16'd0, tssc_pkg::DELAY_BITS'(DELAY_MAX), 16'd0); // negotiation done
        push_filler(REQ_TIMEOUT, 1'b0);                    // resend block 1
        push_ack(16'd0, 24'd0, 16'd0);                     // duplicate ack
        push_ack(16'd1, tssc_pkg::DELAY_BITS'(DELAY_MAX), 16'd512);
        push_ack(16'd2, 24'd0, 16'(BLEN_MAX));
        push_ack(16'd3, tssc_pkg::DELAY_BITS'(DELAY_MAX), 16'd600);
        push_ack(16'd4, tssc_pkg::DELAY_BITS'(DELAY_MAX), 16'd512);
        // average over threshold
        push_ack(16'd5, tssc_pkg::DELAY_BITS'(DELAY_MAX), 16'd512);
        push_ack(16'd99, 24'd0, 16'd512);                  // wrong block number
        push_filler(REQ_START, 1'b0);
        push_evt(REQ_DGRAM, 1'b0, 16'hFFFF, 16'd1, 1'b0, 24'd0, 16'd512);
        push_filler(REQ_START, 1'b0);
        push_ack(16'd1, 24'd7, 16'd0);                     // short block ends transfer
        push_filler(REQ_TIMEOUT, 1'b0);
        wait_drained();

        // random sessions under several register settings, extremes first
        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_BLOCK_SIZE, 32'd8);
                    write_reg(REG_SLOW_THR, 32'd0);
                end
                1: begin
                    write_reg(REG_BLOCK_SIZE, BLEN_MAX);
                    write_reg(REG_SLOW_THR, 32'hFF_FFFF);
                end
                2: begin
                    write_reg(REG_BLOCK_SIZE, $urandom_range(8, 64));
                    write_reg(REG_SLOW_THR, $urandom_range(0, 2000));
                end
                3: begin
                    write_reg(REG_BLOCK_SIZE, $urandom_range(8, BLEN_MAX));
                    write_reg(REG_SLOW_THR, $urandom_range(0, DELAY_MAX));
                end
                default: begin
                    write_reg(REG_BLOCK_SIZE, 32'd512);
                    write_reg(REG_SLOW_THR, 32'd100000);
                end
            endcase
            queued_cnt = 0;
            while (queued_cnt < 200)
                gen_session();
            wait_drained();
        end

        repeat (20) @(posedge aclk);
        if (err_cnt == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
